// ----- rtl/pdke_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdke_pkg
// Shared widths, reset values and the queue word type of the k-mer extractor.
// ----------------------------------------------------------------------------
package pdke_pkg;

    localparam int KMER_W    = 64;
    localparam int CNT_W     = 6;
    localparam int BYTE_W    = 8;
    localparam int BASES_W   = 6;
    localparam int OP_W      = 2;
    localparam int TAG_W     = 2;

    localparam logic [CNT_W-1:0] LEN_RESET = 6'd31;

    typedef struct packed {
        logic               start;
        logic [OP_W-1:0]    op;
        logic [TAG_W-1:0]   n;
        logic [BASES_W-1:0] bases;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t word;
    } queue_head_t;

endpackage

// ----- rtl/pdke_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdke_front
// Accepts packed bytes, decodes the count tag, masks unused bits and queues
// the decoded word in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module pdke_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [pdke_pkg::BYTE_W-1:0]        packed_byte,
    input  logic                               start_req,
    input  logic [pdke_pkg::OP_W-1:0]          op,
    input  logic                               pop,
    output pdke_pkg::queue_head_t              head
);

    localparam int DEPTH = 2;

    pdke_pkg::entry_t   mem_reg [DEPTH];
    logic               wr_ptr_reg;
    logic               wr_ptr_next;
    logic               rd_ptr_reg;
    logic               rd_ptr_next;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               push;
    logic               do_pop;
    pdke_pkg::entry_t   decoded;

    always_comb
    begin
        decoded.start = start_req;
        decoded.op    = op;
        decoded.n     = packed_byte[7:6];
        case (packed_byte[7:6])
            2'd3:    decoded.bases = packed_byte[5:0];
            2'd2:    decoded.bases = {2'b00, packed_byte[3:0]};
            2'd1:    decoded.bases = {4'b0000, packed_byte[1:0]};
            default: decoded.bases = '0;
        endcase
    end

    assign in_ready = (count_reg != 2'(DEPTH));
    assign push     = in_valid && in_ready;
    assign do_pop   = pop && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.word  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/pdke_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdke_back
// Takes decoded words from the queue, folds their bases into the k-mer
// accumulator and registers each finished or aborted k-mer for the receiver.
// ----------------------------------------------------------------------------
module pdke_back #(
    parameter int MAX_KMER = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pdke_pkg::queue_head_t              head,
    output logic                               pop,
    input  logic [pdke_pkg::CNT_W-1:0]         kmer_length,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pdke_pkg::KMER_W-1:0]        kmer,
    output logic                               bad_tag
);

    localparam logic [1:0] MODE_PRE_FWD = 2'd0;
    localparam logic [1:0] MODE_PRE_RC  = 2'd1;
    localparam logic [1:0] MODE_SUF_FWD = 2'd2;
    localparam logic [1:0] MODE_SUF_RC  = 2'd3;
    localparam logic [pdke_pkg::CNT_W-1:0] MAX_LEN = pdke_pkg::CNT_W'(MAX_KMER);

    function automatic logic [pdke_pkg::BASES_W-1:0] revcomp(
        input logic [pdke_pkg::BASES_W-1:0] c,
        input logic [1:0]                   t
    );
        logic [pdke_pkg::BASES_W-1:0] r;
        case (t)
            2'd1:    r = {4'b0000, ~c[1:0]};
            2'd2:    r = {2'b00, ~c[1:0], ~c[3:2]};
            2'd3:    r = {~c[1:0], ~c[3:2], ~c[5:4]};
            default: r = '0;
        endcase
        return r;
    endfunction

    logic [pdke_pkg::KMER_W-1:0] acc_reg;
    logic [pdke_pkg::KMER_W-1:0] acc_next;
    logic [pdke_pkg::CNT_W-1:0]  cnt_reg;
    logic [pdke_pkg::CNT_W-1:0]  cnt_next;
    logic                        busy_reg;
    logic                        busy_next;
    logic [1:0]                  mode_reg;
    logic [1:0]                  mode_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [pdke_pkg::KMER_W-1:0] kmer_reg;
    logic [pdke_pkg::KMER_W-1:0] kmer_next;
    logic                        bad_tag_reg;
    logic                        bad_tag_next;

    logic [pdke_pkg::KMER_W-1:0]  acc_c;
    logic [pdke_pkg::CNT_W-1:0]   cnt_c;
    logic                         busy_c;
    logic [1:0]                   mode_c;
    logic [pdke_pkg::CNT_W-1:0]   k;
    logic [pdke_pkg::CNT_W-1:0]   need;
    logic [pdke_pkg::CNT_W-1:0]   cnt_upd;
    logic [1:0]                   t;
    logic [pdke_pkg::BASES_W-1:0] chunk;
    logic [pdke_pkg::BASES_W-1:0] val;
    logic [pdke_pkg::KMER_W-1:0]  acc_upd;
    logic                         emit;
    pdke_pkg::entry_t             w;

    assign w   = head.word;
    assign pop = head.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        acc_c  = w.start ? '0 : acc_reg;
        cnt_c  = w.start ? '0 : cnt_reg;
        busy_c = w.start ? 1'b1 : busy_reg;
        mode_c = w.start ? w.op : mode_reg;

        if (kmer_length == '0)
        begin
            k = pdke_pkg::CNT_W'(1);
        end
        else if (kmer_length > MAX_LEN)
        begin
            k = MAX_LEN;
        end
        else
        begin
            k = kmer_length;
        end

        need = k - cnt_c;
        t    = (pdke_pkg::CNT_W'(w.n) < need) ? w.n : need[1:0];

        if (!mode_c[1])
        begin
            chunk = w.bases >> {(w.n - t), 1'b0};
        end
        else
        begin
            case (t)
                2'd1:    chunk = {4'b0000, w.bases[1:0]};
                2'd2:    chunk = {2'b00, w.bases[3:0]};
                2'd3:    chunk = w.bases;
                default: chunk = '0;
            endcase
        end

        val = (mode_c == MODE_PRE_RC || mode_c == MODE_SUF_RC) ? revcomp(chunk, t) : chunk;

        case (mode_c) inside
            MODE_PRE_FWD, MODE_SUF_RC:
            begin
                case (t)
                    2'd1:    acc_upd = {acc_c[pdke_pkg::KMER_W-3:0], 2'b00} |
                                       pdke_pkg::KMER_W'(val);
                    2'd2:    acc_upd = {acc_c[pdke_pkg::KMER_W-5:0], 4'b0000} |
                                       pdke_pkg::KMER_W'(val);
                    2'd3:    acc_upd = {acc_c[pdke_pkg::KMER_W-7:0], 6'b000000} |
                                       pdke_pkg::KMER_W'(val);
                    default: acc_upd = acc_c;
                endcase
            end
            MODE_PRE_RC, MODE_SUF_FWD:
            begin
                acc_upd = acc_c | (pdke_pkg::KMER_W'(val) << {cnt_c, 1'b0});
            end
            default:
            begin
                acc_upd = acc_c;
            end
        endcase

        cnt_upd = cnt_c + pdke_pkg::CNT_W'(t);
    end

    always_comb
    begin
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        busy_next      = busy_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kmer_next      = kmer_reg;
        bad_tag_next   = bad_tag_reg;
        emit           = 1'b0;

        if (pop)
        begin
            acc_next  = acc_c;
            cnt_next  = cnt_c;
            busy_next = busy_c;
            mode_next = mode_c;
            if (busy_c)
            begin
                if (cnt_c < k && w.n == 2'd0)
                begin
                    busy_next    = 1'b0;
                    emit         = 1'b1;
                    kmer_next    = '0;
                    bad_tag_next = 1'b1;
                end
                else
                begin
                    if (cnt_c < k)
                    begin
                        acc_next = acc_upd;
                        cnt_next = cnt_upd;
                    end
                    if (cnt_next >= k)
                    begin
                        busy_next    = 1'b0;
                        emit         = 1'b1;
                        kmer_next    = acc_next;
                        bad_tag_next = 1'b0;
                    end
                end
            end
            if (emit)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            busy_reg      <= 1'b0;
            mode_reg      <= MODE_PRE_FWD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            busy_reg      <= busy_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kmer_reg    <= kmer_next;
        bad_tag_reg <= bad_tag_next;
    end

    assign out_valid = out_valid_reg;
    assign kmer      = kmer_reg;
    assign bad_tag   = bad_tag_reg;

endmodule

// ----- rtl/packed_dna_kmer_extractor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_dna_kmer_extractor
// Builds a 2-bit-per-base k-mer from tagged packed DNA bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) moves one word: packed_byte, start_req
//   and op. A word with start_req set clears the accumulator and latches op.
//   Output channel (out_valid/out_ready) moves one word per finished k-mer:
//   kmer, and bad_tag when a tag-zero byte aborted the run (kmer is then 0).
//   Configuration channel (cfg_valid/cfg_ready/cfg_data) writes kmer_length;
//   cfg_ready is always high. Write it only while the block is idle.
//   Throughput: one byte per cycle unless the receiver stalls, set by the
//   accumulator update in the back end. A completing byte is queued, popped
//   by the back end, and its result is then held in the output register.
//   A two-word queue parts the front end from the back end; when the
//   receiver stalls, the result holds, the back end stops, and in_ready
//   drops once the queue is full.
//   Reset clears the queue, the accumulator and the output valid flag, and
//   sets kmer_length to 31.
// ----------------------------------------------------------------------------
module packed_dna_kmer_extractor #(
    parameter int MAX_KMER = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [pdke_pkg::BYTE_W-1:0]        packed_byte,
    input  logic                               start_req,
    input  logic [pdke_pkg::OP_W-1:0]          op,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pdke_pkg::KMER_W-1:0]        kmer,
    output logic                               bad_tag,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pdke_pkg::CNT_W-1:0]         cfg_data
);

    logic [pdke_pkg::CNT_W-1:0] kmer_length_reg;
    logic [pdke_pkg::CNT_W-1:0] kmer_length_next;
    pdke_pkg::queue_head_t      head;
    logic                       pop;

    assign cfg_ready        = 1'b1;
    assign kmer_length_next = (cfg_valid && cfg_ready) ? cfg_data : kmer_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg <= pdke_pkg::LEN_RESET;
        end
        else
        begin
            kmer_length_reg <= kmer_length_next;
        end
    end

    pdke_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .packed_byte (packed_byte),
        .start_req   (start_req),
        .op          (op),
        .pop         (pop),
        .head        (head)
    );

    pdke_back #(
        .MAX_KMER (MAX_KMER)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .kmer_length (kmer_length_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kmer        (kmer),
        .bad_tag     (bad_tag)
    );

endmodule

// ----- rtl/pdke_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdke_checker
// Port-level checks of the k-mer extractor, bound to the top level.
// ----------------------------------------------------------------------------
module pdke_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [pdke_pkg::KMER_W-1:0] kmer,
    input logic                        bad_tag
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kmer) && $stable(bad_tag))
        else $error("stalled result word changed");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_tag |-> kmer == '0)
        else $error("aborted k-mer is not zero");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled without a pending result");

    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid && !out_ready))
        else $error("queue filled without an output stall");

endmodule

bind packed_dna_kmer_extractor pdke_checker u_pdke_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kmer      (kmer),
    .bad_tag   (bad_tag)
);

// ----- dv/tb_packed_dna_kmer_extractor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packed_dna_kmer_extractor
// Drives tagged packed DNA words into the k-mer extractor and predicts every
// k-mer and bad-tag flag. An in-bench model tracks the running extraction, and
// each returned word is checked in order. The run covers directed cases, then
// random extractions under several sender and receiver idling mixes,
// back-pressure and length settings.
// ----------------------------------------------------------------------------
module tb_packed_dna_kmer_extractor;

    localparam int MAX_KMER      = 32;
    localparam int RESET_CYCLES  = 12;
    localparam int DRAIN_CYCLES  = 8;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 105;
    localparam int REPORT_CAP    = 40;

    typedef enum logic [pdke_pkg::OP_W-1:0] {
        PREFIX_FWD = 2'd0,
        PREFIX_RC  = 2'd1,
        SUFFIX_FWD = 2'd2,
        SUFFIX_RC  = 2'd3
    } mode_e;

    localparam logic [pdke_pkg::TAG_W-1:0] TAG_EMPTY = 2'd0;

    typedef struct packed {
        logic [pdke_pkg::KMER_W-1:0] kmer;
        logic                        bad_tag;
    } kmer_word_t;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          in_valid    = 1'b0;
    logic                          in_ready;
    logic [pdke_pkg::BYTE_W-1:0]   packed_byte = '0;
    logic                          start_req   = 1'b0;
    logic [pdke_pkg::OP_W-1:0]     op          = '0;
    logic                          out_valid;
    logic                          out_ready   = 1'b0;
    logic [pdke_pkg::KMER_W-1:0]   kmer;
    logic                          bad_tag;
    logic                          cfg_valid   = 1'b0;
    logic                          cfg_ready;
    logic [pdke_pkg::CNT_W-1:0]    cfg_data    = '0;

    // extraction model state
    logic [pdke_pkg::KMER_W-1:0]   kmer_acc    = '0;
    int                            bases_held  = 0;
    logic                          extracting  = 1'b0;
    mode_e                         cur_mode    = PREFIX_FWD;
    logic [pdke_pkg::CNT_W-1:0]    length_reg  = pdke_pkg::LEN_RESET;

    kmer_word_t          pending_kmers[$];
    int                  errors      = 0;
    int                  words_sent  = 0;
    int                  idle_pct    = 0;
    int                  stall_pct   = 0;
    int                  hold_left   = 0;
    int                  quiet       = 0;

    packed_dna_kmer_extractor #(
        .MAX_KMER (MAX_KMER)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .packed_byte (packed_byte),
        .start_req   (start_req),
        .op          (op),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kmer        (kmer),
        .bad_tag     (bad_tag),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int eff_len(input logic [pdke_pkg::CNT_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_KMER)
            return MAX_KMER;
        return int'(v);
    endfunction

    function automatic logic [pdke_pkg::KMER_W-1:0] revcomp_chunk(
        input logic [pdke_pkg::KMER_W-1:0] x,
        input int                          t
    );
        logic [pdke_pkg::KMER_W-1:0] r;
        r = '0;
        for (int i = 0; i < t; i++)
        begin
            r = (r << 2) | (64'd3 - {62'd0, x[1:0]});
            x = x >> 2;
        end
        return r;
    endfunction

    function automatic logic [pdke_pkg::BYTE_W-1:0] make_byte(input int tag);
        return {2'(tag), 6'($urandom)};
    endfunction

    task automatic advance_kmer(
        input  logic [pdke_pkg::BYTE_W-1:0] b,
        input  logic                        s,
        input  logic [pdke_pkg::OP_W-1:0]   o,
        output logic                        hit,
        output kmer_word_t                  res
    );
        int                          k;
        int                          n;
        int                          t;
        logic [pdke_pkg::KMER_W-1:0] bases;
        logic [pdke_pkg::KMER_W-1:0] chunk;
        hit = 1'b0;
        res = '0;
        if (s)
        begin
            kmer_acc   = '0;
            bases_held = 0;
            extracting = 1'b1;
            cur_mode   = mode_e'(o);
        end
        if (!extracting)
            return;
        k = eff_len(length_reg);
        if (bases_held < k)
        begin
            n = int'(b[7:6]);
            if (b[7:6] == TAG_EMPTY)
            begin
                extracting  = 1'b0;
                hit         = 1'b1;
                res.bad_tag = 1'b1;
                return;
            end
            bases = {58'd0, b[5:0]} & ((64'd1 << (2 * n)) - 64'd1);
            t = (n < k - bases_held) ? n : k - bases_held;
            if (cur_mode == PREFIX_FWD || cur_mode == PREFIX_RC)
                chunk = bases >> (2 * (n - t));
            else
                chunk = bases & ((64'd1 << (2 * t)) - 64'd1);
            case (cur_mode)
                PREFIX_FWD: kmer_acc = (kmer_acc << (2 * t)) | chunk;
                PREFIX_RC:  kmer_acc = kmer_acc | (revcomp_chunk(chunk, t) << (2 * bases_held));
                SUFFIX_FWD: kmer_acc = kmer_acc | (chunk << (2 * bases_held));
                default:    kmer_acc = (kmer_acc << (2 * t)) | revcomp_chunk(chunk, t);
            endcase
            bases_held += t;
        end
        if (bases_held >= k)
        begin
            extracting = 1'b0;
            hit        = 1'b1;
            res.kmer   = kmer_acc;
        end
    endtask

    task automatic report(input string what, input logic [pdke_pkg::KMER_W-1:0] got,
                          input logic [pdke_pkg::KMER_W-1:0] want);
        if (errors < REPORT_CAP)
            $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    // check results, track config writes, predict accepted words
    always @(posedge clk)
    begin : result_check
        kmer_word_t want;
        kmer_word_t got;
        logic       hit;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_kmers.size() == 0)
                    report("unexpected result kmer", kmer, '0);
                else
                begin
                    want = pending_kmers.pop_front();
                    if (kmer !== want.kmer)
                        report("kmer", kmer, want.kmer);
                    if (bad_tag !== want.bad_tag)
                        report("bad_tag", {63'd0, bad_tag}, {63'd0, want.bad_tag});
                end
            end
            if (cfg_valid && cfg_ready)
                length_reg = cfg_data;
            if (in_valid && in_ready)
            begin
                advance_kmer(packed_byte, start_req, op, hit, got);
                if (hit)
                    pending_kmers = {pending_kmers, got};
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("packed_dna_kmer_extractor: mismatch");
                $finish;
            end
        end
    end

    task automatic set_idling(input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
    endtask

    task automatic send_word(input logic [pdke_pkg::BYTE_W-1:0] b, input logic s,
                             input logic [pdke_pkg::OP_W-1:0] o);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        packed_byte <= b;
        start_req   <= s;
        op          <= o;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    // drop valid, drain results, let queued words retire
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_kmers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_len(input logic [pdke_pkg::CNT_W-1:0] v);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one start word, then tagged words until the k-mer fills; sometimes noise,
    // an aborting tag-zero word or an abandoned run
    task automatic send_extraction(input int k_eff);
        int got;
        int tag;
        int roll;
        roll = $urandom_range(99);
        if (roll < 6)
        begin
            send_word(make_byte($urandom_range(0, 3)), 1'b0, 2'($urandom));
            return;
        end
        tag = (roll < 9) ? 0 : $urandom_range(1, 3);
        send_word(make_byte(tag), 1'b1, 2'($urandom));
        if (tag == 0)
            return;
        got = tag;
        while (got < k_eff)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
            begin
                send_word(make_byte(0), 1'b0, 2'($urandom));
                return;
            end
            if (roll < 5)
                return;
            tag = $urandom_range(1, 3);
            send_word(make_byte(tag), 1'b0, 2'($urandom));
            got += tag;
        end
    endtask

    task automatic test_reset_length();
        set_idling(0, 0);
        send_word(8'hE4, 1'b1, PREFIX_FWD);
        for (int i = 0; i < 10; i++)
            send_word(make_byte(3), 1'b0, PREFIX_FWD);
        wait_idle();
    endtask

    task automatic test_modes();
        write_len(6'd5);
        for (int m = 0; m < 4; m++)
        begin
            send_word(8'hE4, 1'b1, mode_e'(m));
            send_word(8'hDB, 1'b0, mode_e'(m));
        end
    endtask

    task automatic test_bad_tag();
        send_word(8'h3F, 1'b1, PREFIX_FWD);
        send_word(8'h41, 1'b1, SUFFIX_RC);
        send_word(8'hB6, 1'b0, SUFFIX_RC);
        send_word(8'h3F, 1'b0, SUFFIX_RC);
    endtask

    task automatic test_idle_byte();
        send_word(8'hFF, 1'b0, SUFFIX_RC);
    endtask

    task automatic test_length_floor();
        write_len(6'd0);
        send_word(8'hE7, 1'b1, SUFFIX_FWD);
    endtask

    task automatic test_length_lowered();
        write_len(6'd6);
        send_word(8'hDB, 1'b1, PREFIX_FWD);
        write_len(6'd2);
        send_word(8'h00, 1'b0, PREFIX_FWD);
    endtask

    task automatic test_random();
        logic [pdke_pkg::CNT_W-1:0] lens[8];
        int                         first;
        lens = '{6'd32, 6'd1, 6'd63, 6'd17, 6'd0, 6'd33, 6'd7, 6'($urandom)};
        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: set_idling(0, 0);
                1: set_idling(52, 0);
                2: set_idling(0, 52);
                default: set_idling(34, 34);
            endcase
            write_len(lens[p]);
            first = words_sent;
            while (words_sent - first < PHASE_ITEMS)
                send_extraction(eff_len(lens[p]));
        end
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        write_len(6'd1);
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
            send_word(make_byte($urandom_range(1, 3)), 1'b1, 2'($urandom));
        wait_idle();
    endtask

    task automatic test_drain_pause();
        int first;
        set_idling(34, 34);
        write_len(6'd4);
        for (int r = 0; r < 2; r++)
        begin
            first = words_sent;
            while (words_sent - first < 20)
                send_extraction(4);
            wait_idle();
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_length();
        test_modes();
        test_bad_tag();
        test_idle_byte();
        test_length_floor();
        test_length_lowered();
        test_random();
        test_backpressure();
        test_drain_pause();

        wait_idle();
        if (errors == 0 && pending_kmers.size() == 0)
            $display("packed_dna_kmer_extractor: match");
        else
            $display("packed_dna_kmer_extractor: mismatch");
        $finish;
    end

endmodule
